FILE: hw/rtl/touch_event_fifo_with_rotation_defines.svh
// ----------------------------------------------------------------------------
// Touch event FIFO assertion macros
// Shared concurrent assertion forms for the touch event FIFO.
// ----------------------------------------------------------------------------
`ifndef TOUCH_EVENT_FIFO_WITH_ROTATION_DEFINES_SVH
`define TOUCH_EVENT_FIFO_WITH_ROTATION_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define TEF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tef assertion failed");

// Next-cycle implication, disabled in reset
`define TEF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tef assertion failed");

`endif

FILE: hw/rtl/tef_pkg.sv
// ----------------------------------------------------------------------------
// Touch event FIFO package
// Beat types, operation and register codes, and the orientation table.
// ----------------------------------------------------------------------------
package tef_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int COORD_W       = 12;
  localparam int EXTENT_W      = 13;
  localparam int EVENT_W       = 2;

  // Operation codes; code 3 is a no-op
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Event returned by a pop of an empty FIFO
  localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;

  // Configuration register indexes
  localparam logic [1:0] REG_CALIB_DIR  = 2'd0;
  localparam logic [1:0] REG_DISP_DIR   = 2'd1;
  localparam logic [1:0] REG_DISP_WIDTH = 2'd2;
  localparam logic [1:0] REG_DISP_HGT   = 2'd3;

  localparam logic [EXTENT_W-1:0] WIDTH_RESET  = 13'd480;
  localparam logic [EXTENT_W-1:0] HEIGHT_RESET = 13'd320;

  typedef struct packed {
    logic [1:0]         operation;
    logic [EVENT_W-1:0] touch_event;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
  } in_beat_t;

  typedef struct packed {
    logic [EVENT_W-1:0] popped_event;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
  } out_beat_t;

  // Orientation settings handed to the mapper
  typedef struct packed {
    logic [1:0]          calib_direction;
    logic [1:0]          display_direction;
    logic [EXTENT_W-1:0] display_width;
    logic [EXTENT_W-1:0] display_height;
  } orient_cfg_t;

  typedef enum logic [1:0] {
    MAP_DIRECT = 2'd0,  // x, y
    MAP_MIRROR = 2'd1,  // W-1-x, H-1-y
    MAP_SWAP_W = 2'd2,  // W-1-y, x
    MAP_SWAP_H = 2'd3   // y, H-1-x
  } map_kind_t;

  // Row: calibration direction, column: display direction
  function automatic map_kind_t map_kind(input logic [1:0] calib, input logic [1:0] disp);
    map_kind_t row [4];
    unique case (calib)
      2'd0: row = '{MAP_DIRECT, MAP_MIRROR, MAP_SWAP_W, MAP_SWAP_H};
      2'd1: row = '{MAP_MIRROR, MAP_DIRECT, MAP_SWAP_H, MAP_SWAP_W};
      2'd2: row = '{MAP_SWAP_W, MAP_SWAP_H, MAP_DIRECT, MAP_MIRROR};
      default: row = '{MAP_SWAP_W, MAP_SWAP_H, MAP_MIRROR, MAP_DIRECT};
    endcase
    return row[disp];
  endfunction

endpackage

FILE: hw/rtl/tef_map.sv
// ----------------------------------------------------------------------------
// Touch coordinate mapper
// Rotates and mirrors a raw coordinate by calibration and display direction.
// ----------------------------------------------------------------------------
module tef_map (
  input  tef_pkg::orient_cfg_t           cfg,
  input  logic [tef_pkg::COORD_W-1:0]    raw_x,
  input  logic [tef_pkg::COORD_W-1:0]    raw_y,
  output logic [tef_pkg::COORD_W-1:0]    map_x,
  output logic [tef_pkg::COORD_W-1:0]    map_y
);
  import tef_pkg::*;

  localparam int DIFF_W = EXTENT_W + 1;

  // extent - 1 - v, clamped to the coordinate range
  function automatic logic [COORD_W-1:0] mirror(input logic [EXTENT_W-1:0] extent,
                                                input logic [COORD_W-1:0] v);
    logic [DIFF_W-1:0] diff;
    diff = {1'b0, extent} - DIFF_W'(1) - {{(DIFF_W-COORD_W){1'b0}}, v};
    if (diff[DIFF_W-1]) begin
      return '0;
    end else if (|diff[DIFF_W-2:COORD_W]) begin
      return '1;
    end
    return diff[COORD_W-1:0];
  endfunction

  map_kind_t kind;
  logic [COORD_W-1:0] mir_wx, mir_hy, mir_wy, mir_hx;

  assign kind   = map_kind(cfg.calib_direction, cfg.display_direction);
  assign mir_wx = mirror(cfg.display_width, raw_x);
  assign mir_hy = mirror(cfg.display_height, raw_y);
  assign mir_wy = mirror(cfg.display_width, raw_y);
  assign mir_hx = mirror(cfg.display_height, raw_x);

  // Select the mapping for the current orientation
  always_comb begin
    unique case (kind)
      MAP_DIRECT: begin
        map_x = raw_x;
        map_y = raw_y;
      end
      MAP_MIRROR: begin
        map_x = mir_wx;
        map_y = mir_hy;
      end
      MAP_SWAP_W: begin
        map_x = mir_wy;
        map_y = raw_x;
      end
      default: begin
        map_x = raw_y;
        map_y = mir_hx;
      end
    endcase
  end

endmodule

FILE: hw/rtl/touch_event_fifo_with_rotation.sv
// ----------------------------------------------------------------------------
// Touch event FIFO with rotation
// Ring buffer of touch events whose coordinates are mapped to display space.
// ----------------------------------------------------------------------------
// One operation beat is taken every cycle while the result register is free
// or being drained. A push maps its coordinate and writes the entry store at
// the accepting edge; a pop reads the store at the accepting edge into the
// result register, so its result beat is offered in the next cycle and
// is held until taken. Clear and the unused code give no result beat.
// A push never checks for full: it overwrites, and when the write pointer
// meets the read pointer the FIFO reads as empty. An empty pop returns event
// none with zero coordinates. No clearing pass runs after reset.
module touch_event_fifo_with_rotation #(
  parameter int FIFO_DEPTH = tef_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tef_pkg::in_beat_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tef_pkg::out_beat_t                 out_data,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [tef_pkg::EXTENT_W-1:0]       cfg_data
);
  import tef_pkg::*;

  `include "touch_event_fifo_with_rotation_defines.svh"

  localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FIFO_DEPTH - 1);

  orient_cfg_t        orient;
  logic [IDX_W-1:0]   wr_idx, wr_idx_next;
  logic [IDX_W-1:0]   rd_idx, rd_idx_next;
  logic               in_fire;
  logic               is_push, is_pop, is_clear;
  logic               push_fire, pop_fire;
  logic               fifo_empty;
  logic               none_out;
  logic [COORD_W-1:0] map_x, map_y;
  out_beat_t          store [FIFO_DEPTH];
  out_beat_t          rd_data;
  logic               rd_empty;

  assign in_ready   = !out_valid || out_ready;
  assign in_fire    = in_valid && in_ready;
  assign is_push    = in_data.operation == OP_PUSH;
  assign is_pop     = in_data.operation == OP_POP;
  assign is_clear   = in_data.operation == OP_CLEAR;
  assign push_fire  = in_fire && is_push;
  assign pop_fire   = in_fire && is_pop;
  assign fifo_empty = rd_idx == wr_idx;

  assign wr_idx_next = (wr_idx == IDX_LAST) ? '0 : wr_idx + 1'b1;
  assign rd_idx_next = (rd_idx == IDX_LAST) ? '0 : rd_idx + 1'b1;

  tef_map u_map (
    .cfg   (orient),
    .raw_x (in_data.raw_x),
    .raw_y (in_data.raw_y),
    .map_x (map_x),
    .map_y (map_y)
  );

  // Configuration, pointers and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      orient.calib_direction   <= '0;
      orient.display_direction <= '0;
      orient.display_width     <= WIDTH_RESET;
      orient.display_height    <= HEIGHT_RESET;
      wr_idx                   <= '0;
      rd_idx                   <= '0;
      out_valid                <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CALIB_DIR:  orient.calib_direction   <= cfg_data[1:0];
          REG_DISP_DIR:   orient.display_direction <= cfg_data[1:0];
          REG_DISP_WIDTH: orient.display_width     <= cfg_data;
          default:        orient.display_height    <= cfg_data;
        endcase
      end
      // update pointers per accepted operation
      if (in_fire && is_push) begin
        wr_idx <= wr_idx_next;
      end else if (in_fire && is_pop && !fifo_empty) begin
        rd_idx <= rd_idx_next;
      end else if (in_fire && is_clear) begin
        wr_idx <= rd_idx;
      end
      // hold the result beat until taken
      if (in_fire && is_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Entry store: write on push, registered read on pop
  always_ff @(posedge clk) begin
    if (in_fire && is_push) begin
      store[wr_idx] <= '{popped_event: in_data.touch_event, out_x: map_x, out_y: map_y};
    end
    if (in_fire && is_pop) begin
      rd_data  <= store[rd_idx];
      rd_empty <= fifo_empty;
    end
  end

  // Drop the entry contents on an empty pop
  assign out_data = rd_empty ? out_beat_t'{popped_event: EV_NONE, out_x: '0, out_y: '0}
                             : rd_data;

  assign none_out = out_data.popped_event == EV_NONE;

  `TEF_ASSERT_NEXT(a_pop_gives_beat, clk, rst, pop_fire, out_valid)
  `TEF_ASSERT_NEXT(a_empty_pop_none, clk, rst, pop_fire && fifo_empty, none_out && $stable(rd_idx))
  `TEF_ASSERT_NOW(a_stall_blocks_input, clk, rst, out_valid && !out_ready, !in_ready)
  `TEF_ASSERT_NEXT(a_push_advances, clk, rst, push_fire, wr_idx != $past(wr_idx) && $stable(rd_idx))

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch event FIFO with rotation testbench
// Drives push, pop, clear and unused beats through the FIFO under every
// calibration and display direction pair, with extreme display sizes. A
// scripted opening checks empty pops, extreme coordinates, event zero, clear
// and saturation. Random runs follow: balanced push/pop runs, mixed runs,
// overflow runs near the depth, clear runs, noise. Pop results are checked
// against the script or an in-bench model of ring buffer and orientation.
// ----------------------------------------------------------------------------
module tb_top;
  import tef_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int PHASES      = 16;
  localparam int PHASE_ITEMS = 102;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [EVENT_W-1:0] EV_DOWN    = 2'd1;
  localparam logic [EVENT_W-1:0] EV_MOVE    = 2'd2;
  localparam logic [EVENT_W-1:0] EV_RELEASE = 2'd3;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    in_beat_t            beat;
    logic [1:0]          reg_index;
    logic [EXTENT_W-1:0] reg_value;
    logic                known;
    out_beat_t           result;
  } script_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_GATED} rx_mode_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_beat_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_beat_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [EXTENT_W-1:0] cfg_data  = '0;

  // Scripted expectation that travels with the current input beat
  logic      row_known  = 1'b0;
  out_beat_t row_expect = '0;

  // Shadow orientation settings
  logic [1:0]          cur_calib = '0;
  logic [1:0]          cur_disp  = '0;
  logic [EXTENT_W-1:0] cur_w     = WIDTH_RESET;
  logic [EXTENT_W-1:0] cur_h     = HEIGHT_RESET;

  // Shadow ring buffer
  logic [EVENT_W-1:0] ev_mem [DEPTH];
  logic [COORD_W-1:0] x_mem  [DEPTH];
  logic [COORD_W-1:0] y_mem  [DEPTH];
  int                 wr_ptr = 0;
  int                 rd_ptr = 0;

  out_beat_t   pending_pops [$];
  script_row_t script [$];

  int fail_count      = 0;
  int beats_in        = 0;
  int pops_checked    = 0;
  int overflow_runs   = 0;
  int phase_items     = 0;
  int quiet_cycles    = 0;
  int burst_left      = 1;
  int rx_left         = 0;
  int rx_cycle        = 0;
  rx_mode_t rx_mode   = RX_OPEN;

  touch_event_fifo_with_rotation #(
    .FIFO_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Orientation table: row is calibration direction, column display direction
  function automatic map_kind_t orient_kind(input logic [1:0] calib, input logic [1:0] disp);
    case ({calib, disp})
      4'h0, 4'h5, 4'hA, 4'hF: return MAP_DIRECT;
      4'h1, 4'h4, 4'hB, 4'hE: return MAP_MIRROR;
      4'h2, 4'h7, 4'h8, 4'hC: return MAP_SWAP_W;
      default:                return MAP_SWAP_H;
    endcase
  endfunction

  // extent - 1 - v, clamped to the coordinate range
  function automatic logic [COORD_W-1:0] reflect(input logic [EXTENT_W-1:0] extent,
                                                 input logic [COORD_W-1:0] v);
    int r;
    r = int'(extent) - 1 - int'(v);
    if (r < 0) return '0;
    if (r > 4095) return '1;
    return COORD_W'(r);
  endfunction

  // Apply one operation to the shadow FIFO; returns 1 when a pop result is due
  function automatic bit apply_touch_op(input in_beat_t b, output out_beat_t res);
    logic [COORD_W-1:0] mx;
    logic [COORD_W-1:0] my;
    res = '0;
    case (b.operation)
      OP_PUSH: begin
        case (orient_kind(cur_calib, cur_disp))
          MAP_DIRECT: begin
            mx = b.raw_x;
            my = b.raw_y;
          end
          MAP_MIRROR: begin
            mx = reflect(cur_w, b.raw_x);
            my = reflect(cur_h, b.raw_y);
          end
          MAP_SWAP_W: begin
            mx = reflect(cur_w, b.raw_y);
            my = b.raw_x;
          end
          default: begin
            mx = b.raw_y;
            my = reflect(cur_h, b.raw_x);
          end
        endcase
        ev_mem[wr_ptr] = b.touch_event;
        x_mem[wr_ptr]  = mx;
        y_mem[wr_ptr]  = my;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        return 1'b0;
      end
      OP_POP: begin
        // empty pop returns event none with zero coordinates
        if (rd_ptr == wr_ptr) begin
          res.popped_event = EV_NONE;
        end else begin
          res.popped_event = ev_mem[rd_ptr];
          res.out_x        = x_mem[rd_ptr];
          res.out_y        = y_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % DEPTH;
        end
        return 1'b1;
      end
      OP_CLEAR: begin
        wr_ptr = rd_ptr;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic script_row_t beat_row(input logic [1:0] op, input logic [EVENT_W-1:0] ev,
                                           input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y);
    script_row_t r;
    r = '0;
    r.kind             = ROW_BEAT;
    r.beat.operation   = op;
    r.beat.touch_event = ev;
    r.beat.raw_x       = x;
    r.beat.raw_y       = y;
    return r;
  endfunction

  function automatic script_row_t pop_row(input logic [EVENT_W-1:0] ev,
                                          input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y);
    script_row_t r;
    r = beat_row(OP_POP, '0, '0, '0);
    r.known               = 1'b1;
    r.result.popped_event = ev;
    r.result.out_x        = x;
    r.result.out_y        = y;
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [1:0] idx, input logic [EXTENT_W-1:0] val);
    script_row_t r;
    r = '0;
    r.kind      = ROW_REG;
    r.reg_index = idx;
    r.reg_value = val;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return COORD_W'(cur_w - 1);
      3: return COORD_W'(cur_h);
      default: return COORD_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // Present one beat, hold it until taken, then maybe open a gap
  task automatic drive_beat(input in_beat_t b, input logic known, input out_beat_t want);
    in_data    <= b;
    in_valid   <= 1'b1;
    row_known  <= known;
    row_expect <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 24);
    end
  endtask

  task automatic issue(input logic [1:0] op);
    in_beat_t b;
    b.operation   = op;
    b.touch_event = ($urandom_range(0, 9) == 0) ? EV_NONE : EVENT_W'($urandom_range(1, 3));
    b.raw_x       = pick_coord();
    b.raw_y       = pick_coord();
    drive_beat(b, 1'b0, '0);
    if (op != OP_UNUSED) phase_items++;
  endtask

  // Hold off the sender until every pop result has drained
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pops.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [EXTENT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_CALIB_DIR:  cur_calib = val[1:0];
      REG_DISP_DIR:   cur_disp  = val[1:0];
      REG_DISP_WIDTH: cur_w     = val;
      default:        cur_h     = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver: switch between randomly chosen stall patterns
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode  = rx_mode_t'($urandom_range(0, 3));
      rx_left  = $urandom_range(40, 300);
      rx_cycle = 0;
    end
    rx_left--;
    rx_cycle++;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= (rx_cycle % 24) >= 18;
    endcase
  end

  // Predict on accepted operation beats, check accepted result beats
  always @(posedge clk) begin
    out_beat_t predicted;
    out_beat_t want;
    bit        gives;
    if (!rst) begin
      quiet_cycles++;
      if (in_valid && in_ready) begin
        quiet_cycles = 0;
        beats_in++;
        gives = apply_touch_op(in_data, predicted);
        if (gives) pending_pops.push_back(row_known ? row_expect : predicted);
      end
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        if (pending_pops.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result beat: ev %0d x %0d y %0d",
                     out_data.popped_event, out_data.out_x, out_data.out_y);
        end else begin
          want = pending_pops.pop_front();
          pops_checked++;
          if (out_data.popped_event !== want.popped_event || out_data.out_x !== want.out_x ||
              out_data.out_y !== want.out_y) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("pop mismatch: expected ev %0d x %0d y %0d, got ev %0d x %0d y %0d",
                       want.popped_event, want.out_x, want.out_y,
                       out_data.popped_event, out_data.out_x, out_data.out_y);
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int n;
    // Reset orientation is direct, so most scripted pops read back raw values
    script = '{
      pop_row(EV_NONE, 12'd0, 12'd0),
      beat_row(OP_PUSH, EV_DOWN, 12'd0, 12'd0),
      beat_row(OP_PUSH, EV_RELEASE, 12'd4095, 12'd4095),
      beat_row(OP_PUSH, EV_NONE, 12'd4095, 12'd0),
      beat_row(OP_PUSH, EV_MOVE, 12'd0, 12'd4095),
      beat_row(OP_UNUSED, EV_DOWN, 12'd123, 12'd456),
      pop_row(EV_DOWN, 12'd0, 12'd0),
      pop_row(EV_RELEASE, 12'd4095, 12'd4095),
      pop_row(EV_NONE, 12'd4095, 12'd0),
      pop_row(EV_MOVE, 12'd0, 12'd4095),
      pop_row(EV_NONE, 12'd0, 12'd0),
      beat_row(OP_PUSH, EV_DOWN, 12'd1, 12'd2),
      beat_row(OP_CLEAR, EV_NONE, 12'd0, 12'd0),
      pop_row(EV_NONE, 12'd0, 12'd0),
      // mirrored mapping at 480 x 320; out-of-range coordinates clamp to zero
      reg_row(REG_CALIB_DIR, 13'd1),
      beat_row(OP_PUSH, EV_MOVE, 12'd4095, 12'd0),
      beat_row(OP_PUSH, EV_DOWN, 12'd0, 12'd4095),
      pop_row(EV_MOVE, 12'd0, 12'd319),
      pop_row(EV_DOWN, 12'd479, 12'd0),
      reg_row(REG_DISP_DIR, 13'd2),
      beat_row(OP_PUSH, EV_RELEASE, 12'd100, 12'd200),
      beat_row(OP_POP, EV_NONE, 12'd0, 12'd0),
      reg_row(REG_DISP_WIDTH, 13'd4096),
      reg_row(REG_DISP_HGT, 13'd1),
      beat_row(OP_PUSH, EV_DOWN, 12'd4095, 12'd5),
      beat_row(OP_POP, EV_NONE, 12'd0, 12'd0)
    };

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Scripted opening
    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        settle();
        write_reg(script[i].reg_index, script[i].reg_value);
      end else begin
        drive_beat(script[i].beat, script[i].known, script[i].result);
      end
    end

    // Random runs, one orientation pair per phase, extreme sizes first
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(REG_CALIB_DIR, EXTENT_W'(p % 4));
      write_reg(REG_DISP_DIR, EXTENT_W'(p / 4));
      case (p)
        0: begin
          write_reg(REG_DISP_WIDTH, 13'd1);
          write_reg(REG_DISP_HGT, 13'd1);
        end
        1: begin
          write_reg(REG_DISP_WIDTH, 13'd4096);
          write_reg(REG_DISP_HGT, 13'd4096);
        end
        2: begin
          // outside the usual range: the width drives the upper clamp
          write_reg(REG_DISP_WIDTH, 13'd8191);
          write_reg(REG_DISP_HGT, 13'd0);
        end
        3: begin
          write_reg(REG_DISP_WIDTH, 13'd4096);
          write_reg(REG_DISP_HGT, 13'd1);
        end
        4: begin
          write_reg(REG_DISP_WIDTH, 13'd1);
          write_reg(REG_DISP_HGT, 13'd4096);
        end
        default: begin
          write_reg(REG_DISP_WIDTH, EXTENT_W'($urandom_range(1, 4096)));
          write_reg(REG_DISP_HGT, EXTENT_W'($urandom_range(1, 4096)));
        end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          n = $urandom_range(1, 8);
          repeat (n) issue(OP_PUSH);
          repeat (n + $urandom_range(0, 1)) issue(OP_POP);
        end else if (pick < 65) begin
          repeat ($urandom_range(4, 16)) issue($urandom_range(0, 1) ? OP_PUSH : OP_POP);
        end else if (pick < 77) begin
          // run around the depth so the write pointer can lap the read pointer
          overflow_runs++;
          repeat ($urandom_range(DEPTH - 2, DEPTH + 2)) issue(OP_PUSH);
          repeat ($urandom_range(1, 3)) issue(OP_POP);
        end else if (pick < 87) begin
          repeat ($urandom_range(1, 5)) issue(OP_PUSH);
          issue(OP_CLEAR);
          issue(OP_POP);
        end else begin
          issue(2'($urandom_range(0, 3)));
        end
      end
    end

    settle();
    repeat (6) @(negedge clk);
    fail_count += pending_pops.size();

    $display("Ran %0d operation beats over %0d orientation phases with %0d overflow runs;",
             beats_in, PHASES, overflow_runs);
    $display("%0d pop results compared, %0d mismatches.", pops_checked, fail_count);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: touch_event_fifo_with_rotation.f
+incdir+hw/rtl
hw/rtl/tef_pkg.sv
hw/rtl/tef_map.sv
hw/rtl/touch_event_fifo_with_rotation.sv
verif/tb_top.sv
